// ===== rtl/terminal_line_editor_assert.svh =====
// Assertion macros shared by the line editor checkers.
// Depends on a clk and an arst_n signal in the scope of use.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define TLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TLE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/tle_pkg.sv =====
// Types and constants of the terminal line editor.
// No dependencies; used by the cell, the top level and the checker.
package tle_pkg;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_CHAR = 3'd1,
		EV_END  = 3'd2,
		EV_EOF  = 3'd3,
		EV_FULL = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [5:0]  pos;
		logic [7:0]  din;
	} cell_ctrl_t;

	localparam logic [7:0] KEY_EOT   = 8'd4;
	localparam logic [7:0] KEY_BS    = 8'd8;
	localparam logic [7:0] KEY_LF    = 8'd10;
	localparam logic [7:0] KEY_CR    = 8'd13;
	localparam logic [7:0] KEY_ESC   = 8'd27;
	localparam logic [7:0] KEY_SPACE = 8'd32;
	localparam logic [7:0] KEY_DEL   = 8'd127;
	localparam logic [7:0] KEY_LBRK  = 8'h5B;
	localparam logic [7:0] KEY_3     = 8'h33;
	localparam logic [7:0] KEY_TILDE = 8'h7E;
	localparam logic [7:0] KEY_RIGHT = 8'h43;
	localparam logic [7:0] KEY_LEFT  = 8'h44;

endpackage

// ===== rtl/terminal_line_editor.sv =====
// Terminal line editor: raw key bytes in, edit events and line characters out.
// A byte that edits the line gives one result item; insert and delete move the
// tail of the line in the same cycle that the byte is taken, because each
// character cell loads from its neighbor. The result sits in one output register,
// and a byte is taken only in a cycle where that register is empty or being read,
// so a stalled result holds off the input. After CR or LF the line leaves at one
// character per cycle that the output is free, from cell zero while the whole row
// shifts left, followed by the end item: length+1 items in all. No new byte is
// taken until the end item has been loaded.
// Depends on tle_pkg and tle_cell.
module terminal_line_editor #(
	parameter int LINE_CAPACITY = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] key_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] char_out, [13:8] cursor, [19:14] length,
	                              // [23:20] zero
	output logic [2:0]  m_tuser,  // [2:0] event_res
	output logic        m_tlast   // last
);
	import tle_pkg::*;

	localparam logic [5:0] CapC = 6'(LINE_CAPACITY);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_BRK,
		PH_SKIP,
		PH_DEL3
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	phase_t     phase_q, phase_nxt;
	state_t     state_q, state_nxt;
	logic [5:0] cursor_q, cursor_nxt;
	logic [5:0] length_q, length_nxt;
	logic [5:0] remain_q, remain_nxt;
	logic       m_valid_q;
	logic [2:0] m_ev_q;
	logic [7:0] m_char_q;
	logic [5:0] m_cur_q, m_len_q;
	logic       m_last_q;

	logic       out_free, accept, load;
	event_t     ld_ev;
	logic [7:0] ld_char;
	logic       ld_last;
	cell_ctrl_t ctrl;
	logic [7:0] b;

	logic [7:0] row [LINE_CAPACITY];

	for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
		logic [7:0] left_d, right_d;
		if (i == 0) begin : g_l0
			assign left_d = 8'h00;
		end else begin : g_ln
			assign left_d = row[i-1];
		end
		if (i == LINE_CAPACITY - 1) begin : g_rl
			assign right_d = 8'h00;
		end else begin : g_rn
			assign right_d = row[i+1];
		end
		tle_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.left_data (left_d),
			.right_data(right_d),
			.data      (row[i])
		);
	end

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata;

	always_comb begin
		phase_nxt  = phase_q;
		state_nxt  = state_q;
		cursor_nxt = cursor_q;
		length_nxt = length_q;
		remain_nxt = remain_q;
		load       = 1'b0;
		ld_ev      = EV_NONE;
		ld_char    = 8'h00;
		ld_last    = 1'b1;
		ctrl.op    = CELL_HOLD;
		ctrl.pos   = cursor_q;
		ctrl.din   = b;

		if (state_q == ST_EMIT) begin
			if (out_free) begin
				load = 1'b1;
				if (remain_q != 6'd0) begin
					// hand out cell zero and advance the row
					ld_ev      = EV_CHAR;
					ld_char    = row[0];
					ld_last    = 1'b0;
					remain_nxt = remain_q - 6'd1;
					ctrl.op    = CELL_DEL;
					ctrl.pos   = 6'd0;
				end else begin
					ld_ev     = EV_END;
					state_nxt = ST_IDLE;
				end
			end
		end else if (accept) begin
			load = 1'b1;
			case (phase_q)
				PH_ESC: phase_nxt = (b == KEY_LBRK) ? PH_BRK : PH_SKIP;
				PH_BRK: begin
					phase_nxt = PH_IDLE;
					if (b == KEY_RIGHT && cursor_q < length_q) begin
						cursor_nxt = cursor_q + 6'd1;
					end else if (b == KEY_LEFT && cursor_q != 6'd0) begin
						cursor_nxt = cursor_q - 6'd1;
					end else if (b == KEY_3) begin
						phase_nxt = PH_DEL3;
					end
				end
				PH_DEL3: begin
					phase_nxt = PH_IDLE;
					if (b == KEY_TILDE && cursor_q < length_q) begin
						ctrl.op    = CELL_DEL;
						length_nxt = length_q - 6'd1;
					end
				end
				PH_SKIP: phase_nxt = PH_IDLE;
				default: begin
					if (b == KEY_CR || b == KEY_LF) begin
						load       = 1'b0;
						remain_nxt = length_q;
						cursor_nxt = 6'd0;
						length_nxt = 6'd0;
						state_nxt  = ST_EMIT;
					end else if (b == KEY_EOT) begin
						ld_ev = EV_EOF;
					end else if (b == KEY_ESC) begin
						phase_nxt = PH_ESC;
					end else if (b == KEY_DEL || b == KEY_BS) begin
						if (cursor_q != 6'd0) begin
							ctrl.op    = CELL_DEL;
							ctrl.pos   = cursor_q - 6'd1;
							cursor_nxt = cursor_q - 6'd1;
							length_nxt = length_q - 6'd1;
						end
					end else if (b >= KEY_SPACE && b < KEY_DEL) begin
						if (length_q < CapC) begin
							ctrl.op    = CELL_INS;
							cursor_nxt = cursor_q + 6'd1;
							length_nxt = length_q + 6'd1;
						end else begin
							ld_ev = EV_FULL;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			state_q   <= ST_IDLE;
			cursor_q  <= 6'd0;
			length_q  <= 6'd0;
			remain_q  <= 6'd0;
			m_valid_q <= 1'b0;
			m_ev_q    <= EV_NONE;
			m_char_q  <= 8'h00;
			m_cur_q   <= 6'd0;
			m_len_q   <= 6'd0;
			m_last_q  <= 1'b0;
		end else begin
			phase_q  <= phase_nxt;
			state_q  <= state_nxt;
			cursor_q <= cursor_nxt;
			length_q <= length_nxt;
			remain_q <= remain_nxt;
			if (load) begin
				m_valid_q <= 1'b1;
				m_ev_q    <= ld_ev;
				m_char_q  <= ld_char;
				m_cur_q   <= cursor_nxt;
				m_len_q   <= length_nxt;
				m_last_q  <= ld_last;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, m_len_q, m_cur_q, m_char_q};
	assign m_tuser  = m_ev_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== rtl/tle_cell.sv =====
// One character cell of the line store row.
// Depends on tle_pkg; takes its left or right neighbor's byte on insert or delete.
module tle_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  tle_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          left_data,
	input  logic [7:0]          right_data,
	output logic [7:0]          data
);
	import tle_pkg::*;

	localparam logic [5:0] IdxC = 6'(IDX);

	logic [7:0] data_q;
	logic [7:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		case (ctrl.op)
			CELL_INS: begin
				if (IdxC > ctrl.pos) begin
					data_nxt = left_data;
				end else if (IdxC == ctrl.pos) begin
					data_nxt = ctrl.din;
				end
			end
			CELL_DEL: begin
				if (IdxC >= ctrl.pos) begin
					data_nxt = right_data;
				end
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

// ===== rtl/tle_checker.sv =====
// Port-level checks of the terminal line editor's result stream, bound to the top.
// Depends on tle_pkg and terminal_line_editor_assert.svh.
`include "terminal_line_editor_assert.svh"

module tle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import tle_pkg::*;

	logic [2:0] ev;
	logic [7:0] ch;
	logic [5:0] cur, len;

	assign ev  = m_tuser;
	assign ch  = m_tdata[7:0];
	assign cur = m_tdata[13:8];
	assign len = m_tdata[19:14];

	`TLE_ASSERT(a_cursor_in_line, m_tvalid |-> cur <= len, "cursor beyond line length")
	`TLE_NEVER(a_char_only_on_line, m_tvalid && ev != EV_CHAR && ch != 8'h00, "stray character")
	`TLE_ASSERT(a_last_marks_end, m_tvalid |-> (m_tlast == (ev != EV_CHAR)), "tlast mismatch")
	`TLE_ASSERT(a_emit_cleared, m_tvalid && ev == EV_CHAR |-> cur == 6'd0 && len == 6'd0, "line not cleared")

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
